// ===== src/ychc_pkg.sv =====
// Shared types, constants and register codes for the YCbCr to HSV colour classifier.
// No dependencies; every other file in src takes its names from here by scope.

package ychc_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HUE_MIN = 3'd0,
        CFG_HUE_MAX = 3'd1,
        CFG_SAT_MIN = 3'd2,
        CFG_SAT_MAX = 3'd3,
        CFG_VAL_MIN = 3'd4,
        CFG_VAL_MAX = 3'd5
    } cfg_index_t;

    // Register values after reset.
    localparam logic [8:0] HUE_MIN_RST = 9'd190;
    localparam logic [8:0] HUE_MAX_RST = 9'd250;
    localparam logic [6:0] SAT_MIN_RST = 7'd40;
    localparam logic [6:0] SAT_MAX_RST = 7'd100;
    localparam logic [6:0] VAL_MIN_RST = 7'd40;
    localparam logic [6:0] VAL_MAX_RST = 7'd100;

    // Signed accumulator used by the colour matrix.
    typedef logic signed [27:0] acc_t;

    // Q16 matrix coefficients, studio range scaled up to full range.
    localparam acc_t Q_LUMA = 28'sd76309;
    localparam acc_t Q_CR_R = 28'sd104597;
    localparam acc_t Q_CB_G = 28'sd25664;
    localparam acc_t Q_CR_G = 28'sd53268;
    localparam acc_t Q_CB_B = 28'sd132203;
    localparam acc_t Q_HALF = 28'sd32768;

    // One quotient bit is resolved in each divider stage.
    localparam int DIV_STAGES = 9;

    // Input beat.
    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
    } pix_t;

    // Output beat.
    typedef struct packed {
        logic       in_range;
        logic [8:0] hue_deg;
        logic [6:0] saturation_pct;
        logic [6:0] value_pct;
    } res_t;

    // Configured bounds, as seen by the comparison stage.
    typedef struct packed {
        logic [8:0] hue_min;
        logic [8:0] hue_max;
        logic [6:0] sat_min;
        logic [6:0] sat_max;
        logic [6:0] val_min;
        logic [6:0] val_max;
    } cfg_t;

    // Clamped 8-bit RGB.
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // Rational HSV terms handed from the classifier to the dividers.
    typedef struct packed {
        logic        in_range;
        logic [6:0]  val_pct;
        logic [16:0] hn;
        logic [7:0]  hd;
        logic [14:0] sn;
        logic [7:0]  sd;
    } frac_t;

endpackage

// ===== src/ychc_rgb.sv =====
// Two-stage YCbCr to RGB colour matrix with clamping to 0..255.
// Depends on ychc_pkg for the beat types and the Q16 coefficients.

module ychc_rgb (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ychc_pkg::pix_t    in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ychc_pkg::rgb_t    out_data
);

    typedef struct packed {
        ychc_pkg::acc_t base;
        ychc_pkg::acc_t cr_r;
        ychc_pkg::acc_t cb_g;
        ychc_pkg::acc_t cr_g;
        ychc_pkg::acc_t cb_b;
    } prod_t;

    logic           s1_vld_reg;
    logic           s2_vld_reg;
    logic           s1_rdy;
    logic           s2_rdy;
    prod_t          prod_reg;
    prod_t          prod_next;
    ychc_pkg::rgb_t rgb_reg;
    ychc_pkg::rgb_t rgb_next;

    logic signed [8:0] yl;
    logic signed [8:0] cb;
    logic signed [8:0] cr;
    ychc_pkg::acc_t    acc_r;
    ychc_pkg::acc_t    acc_g;
    ychc_pkg::acc_t    acc_b;

    // Saturate a Q16 accumulator to an 8-bit channel, dropping the fraction.
    function automatic logic [7:0] clamp_channel(input ychc_pkg::acc_t acc);
        logic [7:0] res;
        if (acc[27])
        begin
            res = 8'd0;
        end
        else if (|acc[26:24])
        begin
            res = 8'd255;
        end
        else
        begin
            res = acc[23:16];
        end
        return res;
    endfunction

    // Each stage takes a beat when it is empty or its own beat moves on.
    assign s2_rdy   = !s2_vld_reg || out_ready;
    assign s1_rdy   = !s1_vld_reg || s2_rdy;
    assign in_ready = s1_rdy;

    // Stage one: centre the samples and form the five coefficient products.
    always_comb
    begin
        yl = $signed({1'b0, in_data.luma}) - 9'sd16;
        cb = $signed({1'b0, in_data.chroma_blue}) - 9'sd128;
        cr = $signed({1'b0, in_data.chroma_red}) - 9'sd128;
        prod_next.base = ychc_pkg::acc_t'(yl) * ychc_pkg::Q_LUMA;
        prod_next.cr_r = ychc_pkg::acc_t'(cr) * ychc_pkg::Q_CR_R;
        prod_next.cb_g = ychc_pkg::acc_t'(cb) * ychc_pkg::Q_CB_G;
        prod_next.cr_g = ychc_pkg::acc_t'(cr) * ychc_pkg::Q_CR_G;
        prod_next.cb_b = ychc_pkg::acc_t'(cb) * ychc_pkg::Q_CB_B;
    end

    // Stage two: sum with rounding offset and clamp each channel.
    always_comb
    begin
        acc_r = prod_reg.base + prod_reg.cr_r + ychc_pkg::Q_HALF;
        acc_g = prod_reg.base - prod_reg.cb_g - prod_reg.cr_g + ychc_pkg::Q_HALF;
        acc_b = prod_reg.base + prod_reg.cb_b + ychc_pkg::Q_HALF;
        rgb_next.r = clamp_channel(acc_r);
        rgb_next.g = clamp_channel(acc_g);
        rgb_next.b = clamp_channel(acc_b);
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            if (s1_rdy)
            begin
                s1_vld_reg <= in_valid;
            end
            if (s2_rdy)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
        end
    end

    // Payload registers load only when a real beat arrives.
    always_ff @(posedge clk)
    begin
        if (s1_rdy && in_valid)
        begin
            prod_reg <= prod_next;
        end
        if (s2_rdy && s1_vld_reg)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign out_valid = s2_vld_reg;
    assign out_data  = rgb_reg;

endmodule

// ===== src/ychc_hsv.sv =====
// Two-stage RGB to rational HSV terms, followed by the exact bounds tests.
// Depends on ychc_pkg for the beat types and the bounds structure.

module ychc_hsv (
    input  logic              clk,
    input  logic              rst_n,
    input  ychc_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  ychc_pkg::rgb_t    in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ychc_pkg::frac_t   out_data
);

    typedef struct packed {
        logic [16:0] hn;
        logic [7:0]  hd;
        logic [14:0] sn;
        logic [7:0]  sd;
        logic [14:0] vn;
    } terms_t;

    logic            s1_vld_reg;
    logic            s2_vld_reg;
    logic            s1_rdy;
    logic            s2_rdy;
    terms_t          terms_reg;
    terms_t          terms_next;
    ychc_pkg::frac_t frac_reg;
    ychc_pkg::frac_t frac_next;

    logic [7:0]         mx;
    logic [7:0]         mn;
    logic [7:0]         d;
    logic signed [11:0] t;
    logic signed [18:0] h60;
    logic [18:0]        d360;
    logic signed [18:0] hfix;

    logic [15:0] vx;
    logic [15:0] vq;
    logic        hue_lo;
    logic        hue_hi;
    logic        hue_ok;
    logic        sat_ok;
    logic        val_ok;

    assign s2_rdy   = !s2_vld_reg || out_ready;
    assign s1_rdy   = !s1_vld_reg || s2_rdy;
    assign in_ready = s1_rdy;

    // Stage one: extremes, chroma and the hue, saturation and value numerators.
    always_comb
    begin
        mx = in_data.r;
        if (in_data.g > mx)
        begin
            mx = in_data.g;
        end
        if (in_data.b > mx)
        begin
            mx = in_data.b;
        end
        mn = in_data.r;
        if (in_data.g < mn)
        begin
            mn = in_data.g;
        end
        if (in_data.b < mn)
        begin
            mn = in_data.b;
        end
        d = mx - mn;

        // Sector offset plus the signed difference of the other two channels.
        if (in_data.r == mx)
        begin
            t = $signed(12'(in_data.g)) - $signed(12'(in_data.b));
        end
        else if (in_data.g == mx)
        begin
            t = $signed(12'(d) << 1) + $signed(12'(in_data.b)) - $signed(12'(in_data.r));
        end
        else
        begin
            t = $signed(12'(d) << 2) + $signed(12'(in_data.r)) - $signed(12'(in_data.g));
        end
        h60  = 19'(t) * 19'sd60;
        d360 = 19'(d) * 19'd360;
        hfix = h60;
        if (h60 < 0)
        begin
            hfix = h60 + $signed(d360);
        end

        // A grey pixel has hue 0 and saturation 0 over a unit denominator.
        if (d == 8'd0)
        begin
            terms_next.hn = 17'd0;
            terms_next.hd = 8'd1;
            terms_next.sn = 15'd0;
            terms_next.sd = 8'd1;
        end
        else
        begin
            terms_next.hn = hfix[16:0];
            terms_next.hd = d;
            terms_next.sn = 15'(d) * 15'd100;
            terms_next.sd = mx;
        end
        terms_next.vn = 15'(mx) * 15'd100;
    end

    // Stage two: cross-multiplied bounds tests and value over 255.
    always_comb
    begin
        hue_lo = terms_reg.hn >= 17'(cfg.hue_min) * 17'(terms_reg.hd);
        hue_hi = terms_reg.hn <= 17'(cfg.hue_max) * 17'(terms_reg.hd);
        // A maximum below the minimum selects the band that wraps past zero.
        if (cfg.hue_max < cfg.hue_min)
        begin
            hue_ok = hue_lo || hue_hi;
        end
        else
        begin
            hue_ok = hue_lo && hue_hi;
        end
        sat_ok = (terms_reg.sn >= 15'(cfg.sat_min) * 15'(terms_reg.sd))
              && (terms_reg.sn <= 15'(cfg.sat_max) * 15'(terms_reg.sd));
        val_ok = (terms_reg.vn >= 15'(cfg.val_min) * 15'd255)
              && (terms_reg.vn <= 15'(cfg.val_max) * 15'd255);

        // Exact floor of x / 255 for x below 65535.
        vx = 16'(terms_reg.vn);
        vq = (vx + (vx >> 8) + 16'd1) >> 8;

        frac_next.in_range = hue_ok && sat_ok && val_ok;
        frac_next.val_pct  = vq[6:0];
        frac_next.hn       = terms_reg.hn;
        frac_next.hd       = terms_reg.hd;
        frac_next.sn       = terms_reg.sn;
        frac_next.sd       = terms_reg.sd;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            if (s1_rdy)
            begin
                s1_vld_reg <= in_valid;
            end
            if (s2_rdy)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s1_rdy && in_valid)
        begin
            terms_reg <= terms_next;
        end
        if (s2_rdy && s1_vld_reg)
        begin
            frac_reg <= frac_next;
        end
    end

    assign out_valid = s2_vld_reg;
    assign out_data  = frac_reg;

endmodule

// ===== src/ychc_div.sv =====
// Pipelined restoring dividers for hue and saturation, one quotient bit per stage.
// Depends on ychc_pkg for the beat types and the stage count; the last stage
// is the output register of the block.

module ychc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ychc_pkg::frac_t   in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ychc_pkg::res_t    out_data
);

    typedef struct packed {
        logic        in_range;
        logic [6:0]  val_pct;
        logic [7:0]  hd;
        logic [7:0]  sd;
        logic [16:0] hrem;
        logic [14:0] srem;
        logic [8:0]  hq;
        logic [8:0]  sq;
    } dstage_t;

    logic [ychc_pkg::DIV_STAGES-1:0] vld_reg;
    logic [ychc_pkg::DIV_STAGES-1:0] vld_in;
    logic [ychc_pkg::DIV_STAGES:0]   rdy;
    dstage_t                         stage_reg  [ychc_pkg::DIV_STAGES];
    dstage_t                         stage_in   [ychc_pkg::DIV_STAGES];
    dstage_t                         stage_next [ychc_pkg::DIV_STAGES];

    assign rdy[ychc_pkg::DIV_STAGES] = out_ready;
    assign in_ready                  = rdy[0];

    for (genvar k = 0; k < ychc_pkg::DIV_STAGES; k++)
    begin : g_stage
        localparam int SHIFT = ychc_pkg::DIV_STAGES - 1 - k;

        logic [17:0] hsub;
        logic [16:0] ssub;

        // The first stage starts with the numerators as partial remainders.
        if (k == 0)
        begin : g_first
            assign vld_in[k]            = in_valid;
            assign stage_in[k].in_range = in_data.in_range;
            assign stage_in[k].val_pct  = in_data.val_pct;
            assign stage_in[k].hd       = in_data.hd;
            assign stage_in[k].sd       = in_data.sd;
            assign stage_in[k].hrem     = in_data.hn;
            assign stage_in[k].srem     = in_data.sn;
            assign stage_in[k].hq       = 9'd0;
            assign stage_in[k].sq       = 9'd0;
        end
        else
        begin : g_rest
            assign vld_in[k]   = vld_reg[k-1];
            assign stage_in[k] = stage_reg[k-1];
        end

        // Ready ripples back from the output register.
        assign rdy[k] = !vld_reg[k] || rdy[k+1];

        // Trial subtraction of the shifted divisor; a clear top bit sets this quotient bit.
        always_comb
        begin
            hsub = {1'b0, stage_in[k].hrem} - (18'(stage_in[k].hd) << SHIFT);
            ssub = {2'b00, stage_in[k].srem} - (17'(stage_in[k].sd) << SHIFT);
            stage_next[k] = stage_in[k];
            if (!hsub[17])
            begin
                stage_next[k].hrem      = hsub[16:0];
                stage_next[k].hq[SHIFT] = 1'b1;
            end
            if (!ssub[16])
            begin
                stage_next[k].srem      = ssub[14:0];
                stage_next[k].sq[SHIFT] = 1'b1;
            end
        end
    end

    // Valid bits travel with the beats.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < ychc_pkg::DIV_STAGES; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ychc_pkg::DIV_STAGES; i++)
        begin
            if (rdy[i] && vld_in[i])
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    // Saturation never exceeds 100, so its top quotient bits are always clear.
    assign out_valid               = vld_reg[ychc_pkg::DIV_STAGES-1];
    assign out_data.in_range       = stage_reg[ychc_pkg::DIV_STAGES-1].in_range;
    assign out_data.hue_deg        = stage_reg[ychc_pkg::DIV_STAGES-1].hq;
    assign out_data.saturation_pct = stage_reg[ychc_pkg::DIV_STAGES-1].sq[6:0];
    assign out_data.value_pct      = stage_reg[ychc_pkg::DIV_STAGES-1].val_pct;

endmodule

// ===== src/ycbcr_hsv_color_classifier_top.sv =====
// Top level of the YCbCr to HSV colour classifier: bounds registers and the pipeline.
// Depends on ychc_pkg, ychc_rgb, ychc_hsv and ychc_div.

// The block takes one pixel per clock while in_ready is high and returns one result
// beat per pixel, in order, through its register stages:
// two stages for the colour matrix, two for the HSV terms and bounds tests, and
// nine for the hue and saturation dividers, which resolve one quotient bit a stage.
// Every stage holds its own valid bit and ready ripples back from the output
// register, so empty stages fill while the output waits and a stall drops nothing.
// The user writes the six bounds registers through cfg_wr_en, cfg_index and cfg_data
// only while no pixel is in flight (unchecked); indexes beyond the sixth are ignored.

module ycbcr_hsv_color_classifier_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [ychc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ychc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ychc_pkg::pix_t                      in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ychc_pkg::res_t                      out_data
);

    ychc_pkg::cfg_t  cfg_reg;
    ychc_pkg::rgb_t  rgb_data;
    ychc_pkg::frac_t frac_data;
    logic            rgb_valid;
    logic            rgb_ready;
    logic            frac_valid;
    logic            frac_ready;

    // Bounds registers, masked to their widths.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hue_min <= ychc_pkg::HUE_MIN_RST;
            cfg_reg.hue_max <= ychc_pkg::HUE_MAX_RST;
            cfg_reg.sat_min <= ychc_pkg::SAT_MIN_RST;
            cfg_reg.sat_max <= ychc_pkg::SAT_MAX_RST;
            cfg_reg.val_min <= ychc_pkg::VAL_MIN_RST;
            cfg_reg.val_max <= ychc_pkg::VAL_MAX_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                ychc_pkg::CFG_HUE_MIN: cfg_reg.hue_min <= cfg_data[8:0];
                ychc_pkg::CFG_HUE_MAX: cfg_reg.hue_max <= cfg_data[8:0];
                ychc_pkg::CFG_SAT_MIN: cfg_reg.sat_min <= cfg_data[6:0];
                ychc_pkg::CFG_SAT_MAX: cfg_reg.sat_max <= cfg_data[6:0];
                ychc_pkg::CFG_VAL_MIN: cfg_reg.val_min <= cfg_data[6:0];
                ychc_pkg::CFG_VAL_MAX: cfg_reg.val_max <= cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    // Colour matrix.
    ychc_rgb u_rgb (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (rgb_valid),
        .out_ready (rgb_ready),
        .out_data  (rgb_data)
    );

    // HSV terms and bounds tests.
    ychc_hsv u_hsv (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (rgb_valid),
        .in_ready  (rgb_ready),
        .in_data   (rgb_data),
        .out_valid (frac_valid),
        .out_ready (frac_ready),
        .out_data  (frac_data)
    );

    // Hue and saturation dividers, ending in the output register.
    ychc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (frac_valid),
        .in_ready  (frac_ready),
        .in_data   (frac_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ycbcr_hsv_color_classifier_top: directed and random pixels
// against a local colour-conversion predictor, over several bounds settings.
// Depends on ychc_pkg and the RTL under src.

module tb;

    // Register indexes past the last bounds register; writes to them are dropped.
    localparam logic [ychc_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [ychc_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    // Q16 colour matrix terms for studio range to full range.
    localparam longint K_LUMA = 76309;
    localparam longint K_CR_R = 104597;
    localparam longint K_CB_G = 25664;
    localparam longint K_CR_G = 53268;
    localparam longint K_CB_B = 132203;
    localparam longint K_HALF = 32768;

    // Bounds as written on the port, before masking to the register widths.
    typedef struct packed {
        logic [8:0] hue_min;
        logic [8:0] hue_max;
        logic [8:0] sat_min;
        logic [8:0] sat_max;
        logic [8:0] val_min;
        logic [8:0] val_max;
    } raw_bounds_t;

    // One directed pixel; the result is typed in only where fixed is set.
    typedef struct packed {
        ychc_pkg::pix_t px;
        logic           fixed;
        ychc_pkg::res_t want;
    } probe_t;

    localparam int NUM_PROBES = 24;
    localparam probe_t PROBES [NUM_PROBES] = '{
        {8'd16,  8'd128, 8'd128, 1'b1, 1'b0, 9'd0,   7'd0,   7'd0},
        {8'd235, 8'd128, 8'd128, 1'b1, 1'b0, 9'd0,   7'd0,   7'd100},
        {8'd0,   8'd0,   8'd0,   1'b1, 1'b0, 9'd120, 7'd100, 7'd53},
        {8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 9'd300, 7'd50,  7'd100},
        {8'd126, 8'd128, 8'd128, 1'b0, 24'd0},
        {8'd81,  8'd90,  8'd240, 1'b0, 24'd0},
        {8'd145, 8'd54,  8'd34,  1'b0, 24'd0},
        {8'd41,  8'd240, 8'd110, 1'b0, 24'd0},
        {8'd210, 8'd16,  8'd146, 1'b0, 24'd0},
        {8'd170, 8'd166, 8'd16,  1'b0, 24'd0},
        {8'd106, 8'd202, 8'd222, 1'b0, 24'd0},
        {8'd60,  8'd200, 8'd150, 1'b0, 24'd0},
        {8'd100, 8'd180, 8'd100, 1'b0, 24'd0},
        {8'd128, 8'd160, 8'd120, 1'b0, 24'd0},
        {8'd255, 8'd0,   8'd255, 1'b0, 24'd0},
        {8'd0,   8'd255, 8'd0,   1'b0, 24'd0},
        {8'd255, 8'd0,   8'd0,   1'b0, 24'd0},
        {8'd0,   8'd255, 8'd255, 1'b0, 24'd0},
        {8'd0,   8'd0,   8'd255, 1'b0, 24'd0},
        {8'd255, 8'd255, 8'd0,   1'b0, 24'd0},
        {8'd16,  8'd129, 8'd128, 1'b0, 24'd0},
        {8'd235, 8'd127, 8'd129, 1'b0, 24'd0},
        {8'd128, 8'd255, 8'd128, 1'b0, 24'd0},
        {8'd128, 8'd128, 8'd0,   1'b0, 24'd0}
    };

    // Fixed bounds settings: full band, wrapped band, all zero, top of range,
    // every bit set (masked on the narrow registers), and an empty saturation band.
    localparam int NUM_PRESETS = 6;
    localparam raw_bounds_t PRESETS [NUM_PRESETS] = '{
        {9'd0,   9'd360, 9'd0,   9'd100, 9'd0,   9'd100},
        {9'd300, 9'd60,  9'd20,  9'd100, 9'd10,  9'd90},
        {9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0},
        {9'd359, 9'd359, 9'd100, 9'd100, 9'd100, 9'd100},
        {9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF},
        {9'd100, 9'd200, 9'd80,  9'd20,  9'd0,   9'd100}
    };

    localparam int NUM_PHASES = 8;
    localparam int PHASE_PIXELS = 200;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [ychc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ychc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    ychc_pkg::pix_t                  in_data = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    ychc_pkg::res_t                  out_data;

    // Local copy of the bounds registers, and results still owed by the block.
    ychc_pkg::cfg_t bounds = {ychc_pkg::HUE_MIN_RST, ychc_pkg::HUE_MAX_RST,
                              ychc_pkg::SAT_MIN_RST, ychc_pkg::SAT_MAX_RST,
                              ychc_pkg::VAL_MIN_RST, ychc_pkg::VAL_MAX_RST};
    ychc_pkg::res_t pending_results [$];
    int             pixels_sent = 0;
    int             results_seen = 0;
    int             fault_count = 0;
    logic           steady = 1'b0;

    ycbcr_hsv_color_classifier_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Run limit, far above the length of the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("** ycbcr_hsv_color_classifier_top: FAILED **");
        $finish;
    end

    // A channel accumulator in Q16 becomes a byte: negative gives zero, large gives 255.
    function automatic longint clamp_to_byte(input longint acc);
        longint whole;
        if (acc < 0)
            return 0;
        whole = acc / 65536;
        return (whole > 255) ? 255 : whole;
    endfunction

    // Converts one pixel to RGB and then HSV, and tests it against the given bounds.
    // Hue, saturation and value are kept as fractions so that the tests are exact.
    function automatic ychc_pkg::res_t classify_pixel(input ychc_pkg::pix_t px,
                                                      input ychc_pkg::cfg_t lim);
        longint         yl, cb, cr, base, r, g, b, mx, mn, d, hn, hd, sn, sd, vn;
        logic           hue_ok, sat_ok, val_ok;
        ychc_pkg::res_t res;
        yl = longint'(px.luma) - 16;
        cb = longint'(px.chroma_blue) - 128;
        cr = longint'(px.chroma_red) - 128;
        base = K_LUMA * yl;
        r = clamp_to_byte(base + K_CR_R * cr + K_HALF);
        g = clamp_to_byte(base - K_CB_G * cb - K_CR_G * cr + K_HALF);
        b = clamp_to_byte(base + K_CB_B * cb + K_HALF);
        mx = (r > g) ? r : g;
        mx = (b > mx) ? b : mx;
        mn = (r < g) ? r : g;
        mn = (b < mn) ? b : mn;
        d = mx - mn;

        // A grey pixel has no hue and no saturation; its value still counts.
        if (d == 0)
        begin
            hn = 0;
            hd = 1;
            sn = 0;
            sd = 1;
        end
        else
        begin
            if (r == mx)
                hn = 60 * (g - b);
            else if (g == mx)
                hn = 60 * (2 * d + (b - r));
            else
                hn = 60 * (4 * d + (r - g));
            if (hn < 0)
                hn += 360 * d;
            hd = d;
            sn = 100 * d;
            sd = mx;
        end
        vn = 100 * mx;

        // A hue maximum below the minimum selects the band that wraps through zero.
        if (lim.hue_max < lim.hue_min)
            hue_ok = (hn >= longint'(lim.hue_min) * hd)
                  || (hn <= longint'(lim.hue_max) * hd);
        else
            hue_ok = (hn >= longint'(lim.hue_min) * hd)
                  && (hn <= longint'(lim.hue_max) * hd);
        sat_ok = (sn >= longint'(lim.sat_min) * sd) && (sn <= longint'(lim.sat_max) * sd);
        val_ok = (vn >= longint'(lim.val_min) * 255) && (vn <= longint'(lim.val_max) * 255);

        res.in_range       = hue_ok && sat_ok && val_ok;
        res.hue_deg        = 9'(hn / hd);
        res.saturation_pct = 7'(sn / sd);
        res.value_pct      = 7'(vn / 255);
        return res;
    endfunction

    // Mirrors one register write into the local bounds; spare indexes change nothing.
    function automatic void store_register(input logic [ychc_pkg::CFG_IDX_W-1:0] idx,
                                           input logic [ychc_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            ychc_pkg::CFG_HUE_MIN: bounds.hue_min = data;
            ychc_pkg::CFG_HUE_MAX: bounds.hue_max = data;
            ychc_pkg::CFG_SAT_MIN: bounds.sat_min = data[6:0];
            ychc_pkg::CFG_SAT_MAX: bounds.sat_max = data[6:0];
            ychc_pkg::CFG_VAL_MIN: bounds.val_min = data[6:0];
            ychc_pkg::CFG_VAL_MAX: bounds.val_max = data[6:0];
            default: ;
        endcase
    endfunction

    // A bound mostly inside its meaningful range, now and then any 9-bit pattern.
    function automatic logic [8:0] random_bound(input int top);
        if ($urandom_range(3) == 0)
            return 9'($urandom);
        return 9'($urandom_range(top));
    endfunction

    // Writes all six bounds on consecutive cycles, then both spare indexes.
    task automatic program_bounds(input raw_bounds_t rb);
        logic [ychc_pkg::CFG_IDX_W-1:0]  idx [8];
        logic [ychc_pkg::CFG_DATA_W-1:0] val [8];
        idx = '{ychc_pkg::CFG_HUE_MIN, ychc_pkg::CFG_HUE_MAX, ychc_pkg::CFG_SAT_MIN,
                ychc_pkg::CFG_SAT_MAX, ychc_pkg::CFG_VAL_MIN, ychc_pkg::CFG_VAL_MAX,
                CFG_SPARE_A, CFG_SPARE_B};
        val = '{rb.hue_min, rb.hue_max, rb.sat_min, rb.sat_max,
                rb.val_min, rb.val_max, 9'($urandom), 9'($urandom)};
        for (int i = 0; i < 8; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            store_register(idx[i], val[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Offers one pixel, with random idle cycles ahead of it unless the run is steady.
    // The expected result is queued at the edge that takes the beat.
    task automatic send_pixel(input ychc_pkg::pix_t px, input logic fixed,
                              input ychc_pkg::res_t want);
        while (!steady && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(fixed ? want : classify_pixel(px, bounds));
        pixels_sent++;
    endtask

    // Stops offering pixels and waits until every owed result has come back.
    task automatic settle();
        in_valid <= 1'b0;
        while (results_seen < pixels_sent)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // Output stalls at random, except through the steady stretch.
    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(99) >= 23);
    end

    // Every output beat is checked against the oldest owed result.
    always @(posedge clk)
    begin : check_results
        ychc_pkg::res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no pixel outstanding: %p", out_data);
                fault_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_seen++;
                if (out_data.in_range !== want.in_range)
                begin
                    $error("in_range: expected %0d, got %0d", want.in_range, out_data.in_range);
                    fault_count++;
                end
                if (out_data.hue_deg !== want.hue_deg)
                begin
                    $error("hue_deg: expected %0d, got %0d", want.hue_deg, out_data.hue_deg);
                    fault_count++;
                end
                if (out_data.saturation_pct !== want.saturation_pct)
                begin
                    $error("saturation_pct: expected %0d, got %0d",
                           want.saturation_pct, out_data.saturation_pct);
                    fault_count++;
                end
                if (out_data.value_pct !== want.value_pct)
                begin
                    $error("value_pct: expected %0d, got %0d",
                           want.value_pct, out_data.value_pct);
                    fault_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        raw_bounds_t    rb;
        ychc_pkg::pix_t px;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pixels under the bounds left by reset.
        for (int i = 0; i < NUM_PROBES; i++)
            send_pixel(PROBES[i].px, PROBES[i].fixed, PROBES[i].want);
        settle();

        // Random pixels, one batch per bounds setting; one batch runs without stalls.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph < NUM_PRESETS)
            begin
                rb = PRESETS[ph];
            end
            else
            begin
                rb.hue_min = random_bound(360);
                rb.hue_max = random_bound(360);
                rb.sat_min = random_bound(100);
                rb.sat_max = random_bound(100);
                rb.val_min = random_bound(100);
                rb.val_max = random_bound(100);
            end
            program_bounds(rb);
            steady = (ph == 3);
            for (int n = 0; n < PHASE_PIXELS; n++)
            begin
                case ($urandom_range(9))
                    6, 7:
                    begin
                        // Close to grey, where the hue sectors meet and ties occur.
                        px.luma        = 8'($urandom);
                        px.chroma_blue = 8'(124 + $urandom_range(8));
                        px.chroma_red  = 8'(124 + $urandom_range(8));
                    end
                    8, 9:
                    begin
                        px.luma        = 8'($urandom_range(235, 16));
                        px.chroma_blue = 8'($urandom_range(240, 16));
                        px.chroma_red  = 8'($urandom_range(240, 16));
                    end
                    default: px = ychc_pkg::pix_t'(24'($urandom));
                endcase
                send_pixel(px, 1'b0, '0);
            end
            steady = 1'b0;
            settle();
        end

        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            fault_count++;
        end
        if (fault_count == 0)
            $display("** ycbcr_hsv_color_classifier_top: PASSED **");
        else
            $display("** ycbcr_hsv_color_classifier_top: FAILED **");
        $finish;
    end

endmodule

// ===== ycbcr_hsv_color_classifier_top.f =====
src/ychc_pkg.sv
src/ychc_rgb.sv
src/ychc_hsv.sv
src/ychc_div.sv
src/ycbcr_hsv_color_classifier_top.sv
tb/tb.sv
